[hw/rtl/frac_pkg.sv]
// ----------------------------------------------------------------------------
// frac_pkg
// Shared widths, opcodes, controller commands and status for the fraction
// arithmetic block with gcd reduction.
// ----------------------------------------------------------------------------
package frac_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH;
   localparam int OUT_WIDTH     = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
   localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH);
   localparam int COUNT_WIDTH   = $clog2(MAG_WIDTH);

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } opcode_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL0,
      CMD_MUL1,
      CMD_MUL2,
      CMD_SPLIT,
      CMD_GCD_LOAD,
      CMD_GCD_STEP,
      CMD_DIVN_LOAD,
      CMD_DIV_STEP,
      CMD_DIVN_SAVE,
      CMD_DIVD_SAVE,
      CMD_OUT
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SPLIT,
      ST_CHECK,
      ST_GCD,
      ST_DIVN,
      ST_SAVEN,
      ST_DIVD,
      ST_SAVED,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic zero;
      logic gcd_done;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/frac_req_if.sv]
// ----------------------------------------------------------------------------
// frac_req_if
// Request channel: opcode and two signed fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frac_req_if;
   logic                                         valid;
   logic                                         ready;
   logic [1:0]                                   opcode;
   logic signed [frac_pkg::OPERAND_WIDTH-1:0]    num_a;
   logic signed [frac_pkg::OPERAND_WIDTH-1:0]    den_a;
   logic signed [frac_pkg::OPERAND_WIDTH-1:0]    num_b;
   logic signed [frac_pkg::OPERAND_WIDTH-1:0]    den_b;

   modport source (output valid, opcode, num_a, den_a, num_b, den_b, input ready);
   modport sink   (input valid, opcode, num_a, den_a, num_b, den_b, output ready);
endinterface

[hw/rtl/frac_rsp_if.sv]
// ----------------------------------------------------------------------------
// frac_rsp_if
// Response channel: reduced numerator and denominator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frac_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [frac_pkg::OUT_WIDTH-1:0]    num_out;
   logic signed [frac_pkg::OUT_WIDTH-1:0]    den_out;

   modport source (output valid, num_out, den_out, input ready);
   modport sink   (input valid, num_out, den_out, output ready);
endinterface

[hw/rtl/frac_ctrl.sv]
// ----------------------------------------------------------------------------
// frac_ctrl
// Sequencer: multiply phase, binary gcd loop, two restoring divisions by the
// gcd, then hand-off to the output register.
// ----------------------------------------------------------------------------
module frac_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  frac_pkg::status_type                status,
   output frac_pkg::cmd_type                   cmd
);

   localparam logic [frac_pkg::COUNT_WIDTH-1:0] LAST_STEP =
      frac_pkg::COUNT_WIDTH'(frac_pkg::MAG_WIDTH - 1);

   frac_pkg::state_type                 state_ff, state_in;
   logic [frac_pkg::COUNT_WIDTH-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frac_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = frac_pkg::CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         frac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = frac_pkg::CMD_LOAD;
               state_in = frac_pkg::ST_MUL0;
            end
         end
         frac_pkg::ST_MUL0: begin
            cmd      = frac_pkg::CMD_MUL0;
            state_in = frac_pkg::ST_MUL1;
         end
         frac_pkg::ST_MUL1: begin
            cmd      = frac_pkg::CMD_MUL1;
            state_in = frac_pkg::ST_MUL2;
         end
         frac_pkg::ST_MUL2: begin
            cmd      = frac_pkg::CMD_MUL2;
            state_in = frac_pkg::ST_SPLIT;
         end
         frac_pkg::ST_SPLIT: begin
            cmd      = frac_pkg::CMD_SPLIT;
            state_in = frac_pkg::ST_CHECK;
         end
         frac_pkg::ST_CHECK: begin
            // a zero part means divisor one: nothing to reduce
            if (status.zero) begin
               state_in = frac_pkg::ST_OUT;
            end else begin
               cmd      = frac_pkg::CMD_GCD_LOAD;
               state_in = frac_pkg::ST_GCD;
            end
         end
         frac_pkg::ST_GCD: begin
            if (status.gcd_done) begin
               cmd      = frac_pkg::CMD_DIVN_LOAD;
               cnt_in   = '0;
               state_in = frac_pkg::ST_DIVN;
            end else begin
               cmd = frac_pkg::CMD_GCD_STEP;
            end
         end
         frac_pkg::ST_DIVN: begin
            cmd    = frac_pkg::CMD_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = frac_pkg::ST_SAVEN;
            end
         end
         frac_pkg::ST_SAVEN: begin
            cmd      = frac_pkg::CMD_DIVN_SAVE;
            cnt_in   = '0;
            state_in = frac_pkg::ST_DIVD;
         end
         frac_pkg::ST_DIVD: begin
            cmd    = frac_pkg::CMD_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = frac_pkg::ST_SAVED;
            end
         end
         frac_pkg::ST_SAVED: begin
            cmd      = frac_pkg::CMD_DIVD_SAVE;
            state_in = frac_pkg::ST_OUT;
         end
         frac_pkg::ST_OUT: begin
            // wait for room in the output register
            if (status.out_free) begin
               cmd      = frac_pkg::CMD_OUT;
               state_in = frac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/frac_dp.sv]
// ----------------------------------------------------------------------------
// frac_dp
// Datapath: operand registers, one shared signed multiplier, sign/magnitude
// split, binary gcd unit, one-bit-a-cycle restoring divider, output register.
// ----------------------------------------------------------------------------
module frac_dp (
   input  logic                                        clock,
   input  logic                                        reset,
   input  frac_pkg::cmd_type                           cmd,
   output frac_pkg::status_type                        status,
   input  logic [1:0]                                  req_opcode,
   input  logic signed [frac_pkg::OPERAND_WIDTH-1:0]   req_num_a,
   input  logic signed [frac_pkg::OPERAND_WIDTH-1:0]   req_den_a,
   input  logic signed [frac_pkg::OPERAND_WIDTH-1:0]   req_num_b,
   input  logic signed [frac_pkg::OPERAND_WIDTH-1:0]   req_den_b,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [frac_pkg::OUT_WIDTH-1:0]       rsp_num_out,
   output logic signed [frac_pkg::OUT_WIDTH-1:0]       rsp_den_out
);

   localparam int MW = frac_pkg::MAG_WIDTH;
   localparam int OW = frac_pkg::OUT_WIDTH;
   localparam int W  = frac_pkg::OPERAND_WIDTH;

   frac_pkg::opcode_type         op_ff;
   logic signed [W-1:0]          na_ff, da_ff, nb_ff, db_ff;
   logic signed [MW-1:0]         prod_ff;
   logic signed [MW:0]           acc_ff;
   logic                         n_neg_ff, d_neg_ff;
   logic [MW-1:0]                n_mag_ff, d_mag_ff;
   logic [MW-1:0]                x_ff, y_ff;
   logic [frac_pkg::SHIFT_WIDTH-1:0] k_ff;
   logic [MW-1:0]                g_ff, quo_ff, rem_ff;
   logic                         rsp_valid_ff;
   logic signed [OW-1:0]         num_out_ff, den_out_ff;

   logic signed [W-1:0]          mul_a, mul_b;
   logic signed [MW-1:0]         mul_p;
   logic signed [MW:0]           prod_ext;
   logic signed [MW:0]           acc_abs, prod_abs;
   logic                         x_ge_y;
   logic [MW-1:0]                xy_diff;
   logic [MW:0]                  trial;
   logic                         trial_fit;
   logic                         both_neg;
   logic [MW:0]                  num_val, den_val;

   // shared multiplier operand selection
   always_comb begin
      mul_a = na_ff;
      mul_b = db_ff;
      case (cmd)
         frac_pkg::CMD_MUL0: begin
            mul_a = na_ff;
            mul_b = (op_ff == frac_pkg::OP_MUL) ? nb_ff : db_ff;
         end
         frac_pkg::CMD_MUL1: begin
            mul_a = nb_ff;
            mul_b = da_ff;
         end
         frac_pkg::CMD_MUL2: begin
            mul_a = da_ff;
            mul_b = (op_ff == frac_pkg::OP_DIV) ? nb_ff : db_ff;
         end
         default: begin
            mul_a = na_ff;
            mul_b = db_ff;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_ext = {prod_ff[MW-1], prod_ff};
   assign acc_abs  = acc_ff[MW] ? -acc_ff : acc_ff;
   assign prod_abs = prod_ext[MW] ? -prod_ext : prod_ext;

   assign x_ge_y  = (x_ff >= y_ff);
   assign xy_diff = x_ge_y ? (x_ff - y_ff) : (y_ff - x_ff);

   assign trial     = {rem_ff, quo_ff[MW-1]};
   assign trial_fit = (trial >= {1'b0, g_ff});

   // only a result with both parts negative is made positive
   assign both_neg = n_neg_ff & d_neg_ff;
   assign num_val  = (n_neg_ff & ~both_neg) ? -{1'b0, n_mag_ff} : {1'b0, n_mag_ff};
   assign den_val  = (d_neg_ff & ~both_neg) ? -{1'b0, d_mag_ff} : {1'b0, d_mag_ff};

   always_ff @(posedge clock) begin
      case (cmd)
         frac_pkg::CMD_LOAD: begin
            op_ff <= frac_pkg::opcode_type'(req_opcode);
            na_ff <= req_num_a;
            da_ff <= req_den_a;
            nb_ff <= req_num_b;
            db_ff <= req_den_b;
         end
         frac_pkg::CMD_MUL0: begin
            prod_ff <= mul_p;
         end
         frac_pkg::CMD_MUL1: begin
            acc_ff  <= prod_ext;
            prod_ff <= mul_p;
         end
         frac_pkg::CMD_MUL2: begin
            case (op_ff)
               frac_pkg::OP_ADD: acc_ff <= acc_ff + prod_ext;
               frac_pkg::OP_SUB: acc_ff <= acc_ff - prod_ext;
               default:          acc_ff <= acc_ff;
            endcase
            prod_ff <= mul_p;
         end
         frac_pkg::CMD_SPLIT: begin
            n_neg_ff <= acc_ff[MW];
            n_mag_ff <= acc_abs[MW-1:0];
            d_neg_ff <= prod_ff[MW-1];
            d_mag_ff <= prod_abs[MW-1:0];
         end
         frac_pkg::CMD_GCD_LOAD: begin
            x_ff <= n_mag_ff;
            y_ff <= d_mag_ff;
            k_ff <= '0;
         end
         frac_pkg::CMD_GCD_STEP: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_ff <= x_ff >> 1;
               y_ff <= y_ff >> 1;
               k_ff <= k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_ff <= x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_ff <= y_ff >> 1;
            end else if (x_ge_y) begin
               x_ff <= xy_diff >> 1;
            end else begin
               y_ff <= xy_diff >> 1;
            end
         end
         frac_pkg::CMD_DIVN_LOAD: begin
            g_ff   <= MW'((x_ff | y_ff) << k_ff);
            quo_ff <= n_mag_ff;
            rem_ff <= '0;
         end
         frac_pkg::CMD_DIV_STEP: begin
            if (trial_fit) begin
               rem_ff <= MW'(trial - {1'b0, g_ff});
            end else begin
               rem_ff <= trial[MW-1:0];
            end
            quo_ff <= {quo_ff[MW-2:0], trial_fit};
         end
         frac_pkg::CMD_DIVN_SAVE: begin
            n_mag_ff <= quo_ff;
            quo_ff   <= d_mag_ff;
            rem_ff   <= '0;
         end
         frac_pkg::CMD_DIVD_SAVE: begin
            d_mag_ff <= quo_ff;
         end
         frac_pkg::CMD_OUT: begin
            num_out_ff <= num_val[OW-1:0];
            den_out_ff <= den_val[OW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd == frac_pkg::CMD_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.zero     = (n_mag_ff == '0) || (d_mag_ff == '0);
   assign status.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_num_out = num_out_ff;
   assign rsp_den_out = den_out_ff;

   a_div_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd == frac_pkg::CMD_DIV_STEP |=> rem_ff < g_ff)
      else $error("divider remainder not below divisor");

   a_div_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd == frac_pkg::CMD_DIV_STEP |-> g_ff != '0)
      else $error("division by zero gcd");

   a_split_no_neg_zero: assert property (@(posedge clock) disable iff (reset)
      cmd == frac_pkg::CMD_SPLIT |=> (!n_neg_ff || n_mag_ff != '0))
      else $error("negative zero numerator after split");

   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd == frac_pkg::CMD_OUT |=> rsp_valid_ff)
      else $error("response not presented after load");

endmodule

[hw/rtl/fraction_arithmetic_reduce.sv]
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the gcd of the numerator and denominator magnitudes.
// ----------------------------------------------------------------------------
// sequence: multiply, sign/magnitude split, then, unless either raw part is zero,
//   the binary gcd loop and the one-bit-per-cycle divider (run once for each part);
//   the result then waits for room in the output register
// throughput: one request in flight; the next is taken once the result is registered
// reset: synchronous, clears the sequencer and the response valid
module fraction_arithmetic_reduce (
   input  logic         clock,
   input  logic         reset,
   frac_req_if.sink     req_chan,
   frac_rsp_if.source   rsp_chan
);

   frac_pkg::cmd_type      cmd;
   frac_pkg::status_type   status;

   frac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   frac_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_opcode  (req_chan.opcode),
      .req_num_a   (req_chan.num_a),
      .req_den_a   (req_chan.den_a),
      .req_num_b   (req_chan.num_b),
      .req_den_b   (req_chan.den_b),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_num_out (rsp_chan.num_out),
      .rsp_den_out (rsp_chan.den_out)
   );

endmodule

[bench/fraction_arithmetic_reduce_tb.sv]
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_tb
// Drives signed fraction pairs with all four opcodes into the block. Each
// request's reduced fraction is worked out in the bench in sign-magnitude
// form: cross-multiply, divide by the Euclid gcd, clear a double negative.
// Responses are compared in order under random sender bursts and receiver
// stalls.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reduce_tb;

   localparam int W               = frac_pkg::OPERAND_WIDTH;
   localparam int MW              = frac_pkg::MAG_WIDTH;
   localparam int OW              = frac_pkg::OUT_WIDTH;
   localparam int RANDOM_REQUESTS = 1600;
   localparam int DRAIN_CYCLES    = 160;

   typedef struct {
      frac_pkg::opcode_type   opcode;
      logic signed [W-1:0]    num_a;
      logic signed [W-1:0]    den_a;
      logic signed [W-1:0]    num_b;
      logic signed [W-1:0]    den_b;
   } frac_request_type;

   typedef struct {
      logic signed [OW-1:0] num;
      logic signed [OW-1:0] den;
   } fraction_type;

   typedef struct {
      bit            neg;
      logic [MW:0]   mag;
   } signed_mag_type;

   typedef enum {STALL_NONE, STALL_SOME, STALL_LONG} stall_mode_type;

   class fraction_checker;
      fraction_type  expected_fractions[$];
      int unsigned   failures;
      int unsigned   checked;
      int unsigned   op_count[4];
      int unsigned   zero_parts;
      int unsigned   reduced;
      int unsigned   signs_cleared;

      function signed_mag_type split(logic signed [W-1:0] v);
         signed_mag_type   s;
         logic [W-1:0]     u;
         s.neg = v[W-1];
         // most negative operand gives a magnitude of exactly 2^(w-1)
         u = s.neg ? (~v + 1'b1) : v;
         s.mag = {{(MW+1-W){1'b0}}, u};
         return s;
      endfunction

      function signed_mag_type product(signed_mag_type a, signed_mag_type b);
         signed_mag_type s;
         s.mag = a.mag * b.mag;
         s.neg = (s.mag != 0) && (a.neg != b.neg);
         return s;
      endfunction

      function signed_mag_type total(signed_mag_type a, signed_mag_type b);
         signed_mag_type s;
         if (a.neg == b.neg) begin
            s.mag = a.mag + b.mag;
            s.neg = a.neg;
         end else if (a.mag >= b.mag) begin
            s.mag = a.mag - b.mag;
            s.neg = a.neg;
         end else begin
            s.mag = b.mag - a.mag;
            s.neg = b.neg;
         end
         if (s.mag == 0) s.neg = 1'b0;
         return s;
      endfunction

      function logic signed [OW-1:0] to_field(signed_mag_type v);
         logic [MW:0] bits;
         bits = v.neg ? (~v.mag + 1'b1) : v.mag;
         return bits[OW-1:0];
      endfunction

      function void note_request(frac_request_type r);
         signed_mag_type   na, da, nb, db, n, d, t;
         logic [MW:0]      g, x, y, rem;
         fraction_type     f;
         na = split(r.num_a);
         da = split(r.den_a);
         nb = split(r.num_b);
         db = split(r.den_b);
         op_count[r.opcode]++;
         case (r.opcode)
            frac_pkg::OP_ADD: begin
               n = total(product(na, db), product(nb, da));
               d = product(da, db);
            end
            frac_pkg::OP_SUB: begin
               t = product(nb, da);
               if (t.mag != 0) t.neg = !t.neg;
               n = total(product(na, db), t);
               d = product(da, db);
            end
            frac_pkg::OP_MUL: begin
               n = product(na, nb);
               d = product(da, db);
            end
            default: begin
               n = product(na, db);
               d = product(da, nb);
            end
         endcase
         if (n.mag == 0 || d.mag == 0) begin
            g = (MW+1)'(1);
            zero_parts++;
         end else begin
            x = n.mag;
            y = d.mag;
            while (y != 0) begin
               rem = x % y;
               x = y;
               y = rem;
            end
            g = x;
            if (g != 1) reduced++;
         end
         n.mag = n.mag / g;
         d.mag = d.mag / g;
         if (n.neg && d.neg) begin
            n.neg = 1'b0;
            d.neg = 1'b0;
            signs_cleared++;
         end
         f.num = to_field(n);
         f.den = to_field(d);
         expected_fractions.push_back(f);
      endfunction

      function void check_response(logic signed [OW-1:0] num,
                                   logic signed [OW-1:0] den);
         fraction_type f;
         if (expected_fractions.size() == 0) begin
            $error("response with no request pending: num_out=%0d den_out=%0d", num, den);
            failures++;
            return;
         end
         f = expected_fractions.pop_front();
         checked++;
         if (num !== f.num) begin
            $error("num_out mismatch: expected %0d, got %0d", f.num, num);
            failures++;
         end
         if (den !== f.den) begin
            $error("den_out mismatch: expected %0d, got %0d", f.den, den);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   frac_req_if req_chan ();
   frac_rsp_if rsp_chan ();

   fraction_checker board = new();

   fraction_arithmetic_reduce u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic frac_request_type make_request(frac_pkg::opcode_type op, int na,
                                                     int da, int nb, int db);
      frac_request_type r;
      r.opcode = op;
      r.num_a  = W'(na);
      r.den_a  = W'(da);
      r.num_b  = W'(nb);
      r.den_b  = W'(db);
      return r;
   endfunction

   // mix of full-range, small, extreme and common-factor values
   function automatic logic signed [W-1:0] random_operand();
      int pick;
      int s;
      pick = int'($urandom_range(0, 15));
      s = int'($urandom_range(0, 24)) - 12;
      if (pick < 6) return W'($urandom);
      if (pick < 10) return W'(s);
      if (pick < 12) begin
         case ($urandom_range(0, 4))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return {W{1'b1}};
            3: return W'(1);
            default: return '0;
         endcase
      end
      if (pick < 15) begin
         return W'(s * (1 << $urandom_range(1, 10)) * int'($urandom_range(1, 3)));
      end
      return '0;
   endfunction

   task automatic drive_request(input frac_request_type r);
      @(negedge clock);
      req_chan.valid  = 1'b1;
      req_chan.opcode = r.opcode;
      req_chan.num_a  = r.num_a;
      req_chan.den_a  = r.den_a;
      req_chan.num_b  = r.num_b;
      req_chan.den_b  = r.den_b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_request(r);
   endtask

   // idle cycles carry junk on the payload
   task automatic hold_idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid  = 1'b0;
         req_chan.opcode = 2'($urandom);
         req_chan.num_a  = W'($urandom);
         req_chan.den_a  = W'($urandom);
         req_chan.num_b  = W'($urandom);
         req_chan.den_b  = W'($urandom);
      end
   endtask

   initial begin
      frac_request_type   directed[$];
      frac_request_type   r;
      int                 sent;
      int                 burst;
      int                 gap;

      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.opcode = frac_pkg::OP_ADD;
      req_chan.num_a  = '0;
      req_chan.den_a  = '0;
      req_chan.num_b  = '0;
      req_chan.den_b  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed.push_back(make_request(frac_pkg::OP_ADD, 1, 2, 1, 3));
      directed.push_back(make_request(frac_pkg::OP_SUB, 1, 2, 1, 2));
      directed.push_back(make_request(frac_pkg::OP_MUL, 0, 5, 3, 7));
      directed.push_back(make_request(frac_pkg::OP_DIV, 3, 4, 0, 5));
      directed.push_back(make_request(frac_pkg::OP_ADD, 0, 0, 0, 0));
      directed.push_back(make_request(frac_pkg::OP_DIV, 5, 0, 0, 3));
      directed.push_back(make_request(frac_pkg::OP_DIV, 1, 1, 0, 1));
      directed.push_back(make_request(frac_pkg::OP_MUL, -3, -4, 2, 5));
      directed.push_back(make_request(frac_pkg::OP_MUL, 3, -4, 1, 1));
      directed.push_back(make_request(frac_pkg::OP_MUL, -3, 4, 1, 1));
      directed.push_back(make_request(frac_pkg::OP_MUL, 0, -4, 1, 1));
      directed.push_back(make_request(frac_pkg::OP_ADD, 32767, 32767, 32767, 32767));
      directed.push_back(make_request(frac_pkg::OP_MUL, -32768, -32768, -32768, -32768));
      directed.push_back(make_request(frac_pkg::OP_ADD, -32768, 1, -32768, 1));
      directed.push_back(make_request(frac_pkg::OP_SUB, -32768, 32767, 32767, -32768));
      directed.push_back(make_request(frac_pkg::OP_DIV, -32768, 32767, -32768, 32767));
      directed.push_back(make_request(frac_pkg::OP_ADD, 32767, -32768, 32767, -32768));
      directed.push_back(make_request(frac_pkg::OP_SUB, 32767, 1, -32768, 1));
      directed.push_back(make_request(frac_pkg::OP_ADD, 4, 6, 2, 6));
      directed.push_back(make_request(frac_pkg::OP_SUB, 7, 3, -7, -3));
      directed.push_back(make_request(frac_pkg::OP_DIV, -6, 4, 3, -8));
      directed.push_back(make_request(frac_pkg::OP_DIV, 32767, -1, -1, 32767));

      foreach (directed[i]) begin
         drive_request(directed[i]);
         hold_idle(int'($urandom_range(0, 3)));
      end

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = int'($urandom_range(1, 12));
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 20));
         repeat (burst) begin
            r.opcode = frac_pkg::opcode_type'($urandom_range(0, 3));
            r.num_a  = random_operand();
            r.den_a  = random_operand();
            r.num_b  = random_operand();
            r.den_b  = random_operand();
            drive_request(r);
            sent++;
         end
         hold_idle(gap);
      end
      hold_idle(1);

      while (board.expected_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses: add %0d, subtract %0d, multiply %0d, divide %0d",
               board.checked, board.op_count[frac_pkg::OP_ADD],
               board.op_count[frac_pkg::OP_SUB], board.op_count[frac_pkg::OP_MUL],
               board.op_count[frac_pkg::OP_DIV]);
      $display("%0d with a zero part, %0d reduced by a common factor, %0d signs cleared",
               board.zero_parts, board.reduced, board.signs_cleared);
      if (board.failures == 0 && board.expected_fractions.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // receiver back-pressure, switching between three stall modes at random
   initial begin
      stall_mode_type   mode;
      int               mode_left;
      int               stall_left;

      rsp_chan.ready = 1'b0;
      mode = STALL_NONE;
      mode_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 2));
            mode_left = int'($urandom_range(64, 600));
         end
         mode_left--;
         case (mode)
            STALL_NONE: rsp_chan.ready = 1'b1;
            STALL_SOME: rsp_chan.ready = ($urandom_range(0, 3) != 0);
            default: begin
               if (stall_left > 0) begin
                  rsp_chan.ready = 1'b0;
                  stall_left--;
               end else begin
                  rsp_chan.ready = 1'b1;
                  stall_left = int'($urandom_range(0, 40));
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_response(rsp_chan.num_out, rsp_chan.den_out);
   end

   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
